FILE: rtl/core/current_limit_setpoint_regulator_defines.svh
// Assertion macros for the current-limit setpoint regulator.
// Included by the top level; expects clk_i and rst_ni in the including scope.
`ifndef CURRENT_LIMIT_SETPOINT_REGULATOR_DEFINES_SVH
`define CURRENT_LIMIT_SETPOINT_REGULATOR_DEFINES_SVH

// Invariant checked at every clock edge out of reset
`define CLR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequence checked in the same cycle
`define CLR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent
`define CLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/clr_pkg.sv
// Shared types, constants and helpers of the current-limit setpoint regulator.
// No dependencies; used by the serial multiplier, serial divider and top level.
package clr_pkg;

  // Field widths
  localparam int SetpointW = 15;
  localparam int CodeW     = 8;
  localparam int DacW      = 12;
  localparam int NumW      = 23;  // vcode * 100 * limit fits in 23 bits
  localparam int McandW    = 15;  // vcode * 100 fits in 15 bits

  // Serial step counts
  localparam int MulSteps = CodeW;
  localparam int DivSteps = SetpointW;
  localparam int MulCntW  = $clog2(MulSteps);
  localparam int DivCntW  = $clog2(DivSteps);

  // Command codes
  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdMeasure = 1'b1;

  // Setpoint limits and scaling
  localparam logic [SetpointW-1:0] SetpointMinMv = 15'd2000;
  localparam logic [SetpointW-1:0] SetpointMaxMv = 15'd20000;
  localparam logic [McandW-1:0]    MvPerVcode    = 15'd100;
  localparam logic [CodeW-1:0]     LimitReset    = 8'd200;

  // dac = floor(mv * 819 / 4000) = floor(mv * DacRecip / 2^DacShift) for mv <= 20000
  localparam int              DacShift = 27;
  localparam int              DacProdW = 40;
  localparam logic [24:0]     DacRecip = 25'd27481080;
  // readback = floor(mv / 100) = floor(mv * RbRecip / 2^RbShift) for mv <= 20000
  localparam int              RbShift  = 19;
  localparam int              RbProdW  = 28;
  localparam logic [12:0]     RbRecip  = 13'd5243;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  // Saturate a millivolt value to the legal setpoint range
  function automatic logic [SetpointW-1:0] clamp_mv(input logic [SetpointW-1:0] mv);
    logic [SetpointW-1:0] res;
    if (mv < SetpointMinMv) begin
      res = SetpointMinMv;
    end else if (mv > SetpointMaxMv) begin
      res = SetpointMaxMv;
    end else begin
      res = mv;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/clr_mul_serial.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Depends on clr_pkg for widths and the status struct.
module clr_mul_serial (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [clr_pkg::McandW-1:0]    mcand_i,
  input  logic [clr_pkg::CodeW-1:0]     mplier_i,
  output clr_pkg::ser_stat_t            stat_o,
  output logic [clr_pkg::NumW-1:0]      product_o
);

  localparam logic [clr_pkg::MulCntW-1:0] LastStep = clr_pkg::MulCntW'(clr_pkg::MulSteps - 1);

  logic                         busy_q;
  logic                         done_q;
  logic [clr_pkg::MulCntW-1:0]  cnt_q;
  logic [clr_pkg::NumW-1:0]     acc_q;
  logic [clr_pkg::NumW-1:0]     mcand_q;
  logic [clr_pkg::CodeW-1:0]    mplier_q;

  // Sequence the steps and flag the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Add the shifted multiplicand when the current multiplier bit is set
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= clr_pkg::NumW'(mcand_i);
      mplier_q <= mplier_i;
    end else if (busy_q) begin
      acc_q    <= mplier_q[0] ? acc_q + mcand_q : acc_q;
      mcand_q  <= {mcand_q[clr_pkg::NumW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[clr_pkg::CodeW-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign product_o   = acc_q;

endmodule

FILE: rtl/core/clr_div_serial.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on clr_pkg; the caller guarantees the initial remainder is below the divisor.
module clr_div_serial (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [clr_pkg::SetpointW-1:0] dividend_i,
  input  logic [clr_pkg::CodeW-1:0]     rem_init_i,
  input  logic [clr_pkg::CodeW-1:0]     divisor_i,
  output clr_pkg::ser_stat_t            stat_o,
  output logic [clr_pkg::SetpointW-1:0] quotient_o
);

  localparam logic [clr_pkg::DivCntW-1:0] LastStep = clr_pkg::DivCntW'(clr_pkg::DivSteps - 1);

  logic                           busy_q;
  logic                           done_q;
  logic [clr_pkg::DivCntW-1:0]    cnt_q;
  logic [clr_pkg::CodeW-1:0]      rem_q;
  logic [clr_pkg::CodeW-1:0]      div_q;
  logic [clr_pkg::SetpointW-1:0]  num_q;
  logic [clr_pkg::CodeW:0]        trial;
  logic [clr_pkg::CodeW:0]        diff;
  logic                           fits;

  // Sequence the steps and flag the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, num_q[clr_pkg::SetpointW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  // Shift quotient bits into the dividend register as it empties
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      div_q <= divisor_i;
      num_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[clr_pkg::CodeW-1:0] : trial[clr_pkg::CodeW-1:0];
      num_q <= {num_q[clr_pkg::SetpointW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = num_q;

endmodule

FILE: rtl/core/current_limit_setpoint_regulator.sv
// Top level of the current-limit setpoint regulator: control FSM, setpoint and output register.
// Depends on clr_pkg, clr_mul_serial, clr_div_serial and the assertion macro header.
//
//   channel   direction   signals                                           width
//   in        request     in_valid_i/in_ready_o, command_i, new_setpoint_mv_i, 1/15/8/8
//                         voltage_code_i, current_code_i
//   out       result      out_valid_o/out_ready_i, dac_code_o,               12/15/8/1
//                         setpoint_out_mv_o, setpoint_readback_o, limiting_o
//   cfg       write       cfg_valid_i/cfg_ready_o, cfg_data_i (current limit) 8
//
// A load request or a measurement within the limit goes from ST_IDLE to ST_OUT and back.
// A measurement over the limit runs 8 serial multiplier steps, then 15 serial divider
// steps, and skips the divider when the quotient already overflows the 15-bit range.
// Reset sets the setpoint to 2000 mV and the limit to 200; no clearing pass is needed.
// A stalled result holds in the output register while the next request is still accepted.
`include "current_limit_setpoint_regulator_defines.svh"

module current_limit_setpoint_regulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [clr_pkg::CodeW-1:0]     cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [clr_pkg::SetpointW-1:0] new_setpoint_mv_i,
  input  logic [clr_pkg::CodeW-1:0]     voltage_code_i,
  input  logic [clr_pkg::CodeW-1:0]     current_code_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [clr_pkg::DacW-1:0]      dac_code_o,
  output logic [clr_pkg::SetpointW-1:0] setpoint_out_mv_o,
  output logic [clr_pkg::CodeW-1:0]     setpoint_readback_o,
  output logic                          limiting_o
);

  clr_pkg::state_e                state_q, state_d;
  logic [clr_pkg::SetpointW-1:0]  setpoint_q, setpoint_d;
  logic [clr_pkg::CodeW-1:0]      limit_q;
  logic [clr_pkg::CodeW-1:0]      ccode_q, ccode_d;
  logic                           limiting_q, limiting_d;
  logic                           mul_start;
  logic                           div_start;
  logic                           out_load;
  logic                           out_valid_q;
  logic [clr_pkg::DacW-1:0]       dac_q;
  logic [clr_pkg::SetpointW-1:0]  sp_out_q;
  logic [clr_pkg::CodeW-1:0]      readback_q;
  logic                           lim_out_q;
  logic [clr_pkg::McandW-1:0]     vcode_mv;
  clr_pkg::ser_stat_t             mul_stat;
  clr_pkg::ser_stat_t             div_stat;
  logic [clr_pkg::NumW-1:0]       product;
  logic [clr_pkg::SetpointW-1:0]  quotient;
  logic [clr_pkg::DacProdW-1:0]   dac_prod;
  logic [clr_pkg::RbProdW-1:0]    rb_prod;

  // Configuration register is always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= clr_pkg::LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Measured voltage in millivolts feeds the multiplier
  assign vcode_mv = clr_pkg::McandW'(voltage_code_i) * clr_pkg::MvPerVcode;

  clr_mul_serial u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (vcode_mv),
    .mplier_i  (limit_q),
    .stat_o    (mul_stat),
    .product_o (product)
  );

  clr_div_serial u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product[clr_pkg::SetpointW-1:0]),
    .rem_init_i (product[clr_pkg::NumW-1:clr_pkg::SetpointW]),
    .divisor_i  (ccode_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // State and setpoint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= clr_pkg::ST_IDLE;
      setpoint_q <= clr_pkg::SetpointMinMv;
      limiting_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      setpoint_q <= setpoint_d;
      limiting_q <= limiting_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ccode_q <= ccode_d;
  end

  // Next state: load, check the limit, run multiplier then divider, hand off the result
  always_comb begin
    state_d    = state_q;
    setpoint_d = setpoint_q;
    limiting_d = limiting_q;
    ccode_d    = ccode_q;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      clr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ccode_d = current_code_i;
          if (command_i == clr_pkg::CmdLoad) begin
            setpoint_d = clr_pkg::clamp_mv(new_setpoint_mv_i);
            limiting_d = 1'b0;
            state_d    = clr_pkg::ST_OUT;
          end else if (current_code_i > limit_q) begin
            mul_start  = 1'b1;
            limiting_d = 1'b1;
            state_d    = clr_pkg::ST_MUL;
          end else begin
            limiting_d = 1'b0;
            state_d    = clr_pkg::ST_OUT;
          end
        end
      end
      clr_pkg::ST_MUL: begin
        if (mul_stat.done) begin
          // Quotient of 2^15 or more saturates without dividing
          if (product[clr_pkg::NumW-1:clr_pkg::SetpointW] >= ccode_q) begin
            setpoint_d = clr_pkg::SetpointMaxMv;
            state_d    = clr_pkg::ST_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = clr_pkg::ST_DIV;
          end
        end
      end
      clr_pkg::ST_DIV: begin
        if (div_stat.done) begin
          setpoint_d = clr_pkg::clamp_mv(quotient);
          state_d    = clr_pkg::ST_OUT;
        end
      end
      clr_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = clr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = clr_pkg::ST_IDLE;
      end
    endcase
  end

  // Scale the setpoint to DAC and readback codes by reciprocal multiplication
  assign dac_prod = clr_pkg::DacProdW'(setpoint_q) * clr_pkg::DacProdW'(clr_pkg::DacRecip);
  assign rb_prod  = clr_pkg::RbProdW'(setpoint_q) * clr_pkg::RbProdW'(clr_pkg::RbRecip);

  // Output register: hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dac_q      <= dac_prod[clr_pkg::DacShift+clr_pkg::DacW-1:clr_pkg::DacShift];
      sp_out_q   <= setpoint_q;
      readback_q <= rb_prod[clr_pkg::RbShift+clr_pkg::CodeW-1:clr_pkg::RbShift];
      lim_out_q  <= limiting_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign dac_code_o          = dac_q;
  assign setpoint_out_mv_o   = sp_out_q;
  assign setpoint_readback_o = readback_q;
  assign limiting_o          = lim_out_q;

  // Checks
  `CLR_ASSERT_ALWAYS(a_setpoint_range, (setpoint_q >= clr_pkg::SetpointMinMv) && (setpoint_q <= clr_pkg::SetpointMaxMv), "setpoint left 2000..20000 mV")
  `CLR_ASSERT_ALWAYS(a_units_exclusive, !(mul_stat.busy && div_stat.busy), "multiplier and divider busy together")
  `CLR_ASSERT_NEXT(a_load_setpoint, in_valid_i && in_ready_o && (command_i == clr_pkg::CmdLoad), setpoint_q == clr_pkg::clamp_mv($past(new_setpoint_mv_i)), "load request did not set clamped setpoint")
  `CLR_ASSERT_NEXT(a_within_limit_keeps, in_valid_i && in_ready_o && (command_i == clr_pkg::CmdMeasure) && (current_code_i <= limit_q), $stable(setpoint_q) && !limiting_q, "setpoint changed with current within limit")

endmodule
